[rtl/core/physical_extent_allocator_assert.svh]
// Assertion macros used by the extent allocator top level.
`ifndef PHYSICAL_EXTENT_ALLOCATOR_ASSERT_SVH
`define PHYSICAL_EXTENT_ALLOCATOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define PEA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("extent allocator assertion failed");

// Check cons in the cycle after ante.
`define PEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("extent allocator assertion failed");

`endif

[rtl/core/pea_pkg.sv]
// Types, codes and constants of the extent allocator.
package pea_pkg;

    localparam int TABLE_DEPTH_DEF = 256;

    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 48;
    localparam int SP_W       = 37;   // start page; a split can push it one bit past 36
    localparam int PG_W       = 36;
    localparam int END_W      = 38;
    localparam int REQ_W      = 37;
    localparam int TYPE_W     = 5;
    localparam int FUNC_W     = 3;
    localparam int STAT_W     = 3;
    localparam int USED_W     = 9;
    localparam int IN_W       = 144;
    localparam int OUT_W      = 152;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [TYPE_W-1:0] FREE_TYPE_RST = 5'd7;
    localparam logic [PG_W-1:0]   PAGES_MAX     = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SERVICE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_TYPE = 1'd1;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOAD       = 3'd0,
        FN_FIXED      = 3'd1,
        FN_FIRST_FIT  = 3'd2,
        FN_FREE       = 3'd3,
        FN_QUERY      = 3'd4,
        FN_MERGE      = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOMEM    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_EV,
        S_ALLOC,
        S_WALK_RD,
        S_WALK_EV,
        S_WALK_END,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0] ty;
        logic [PG_W-1:0]   pg;
        logic [SP_W-1:0]   sp;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    function automatic t_row mk_row(input logic [SP_W-1:0] sp, input logic [PG_W-1:0] pg,
                                    input logic [TYPE_W-1:0] ty);
        t_row r;
        r.sp = sp;
        r.pg = pg;
        r.ty = ty;
        return r;
    endfunction

    function automatic logic [PG_W-1:0] sat_add(input logic [PG_W-1:0] a,
                                                input logic [PG_W-1:0] b);
        logic [PG_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[PG_W] ? PAGES_MAX : s[PG_W-1:0];
    endfunction

endpackage

[rtl/core/physical_extent_allocator.sv]
// Top level of the extent allocator: request sequencer, extent table and result register.
//
// The extent table sits in one RAM with one write and one registered read port, and every
// request is worked through it one row at a time by a small sequencer; each row visited
// takes a read issue and then a use of the returned data. Query finishes after the lookup
// alone and load appends a row without a scan; a first-fit allocation scans for a fitting
// extent and then looks its start up again, and splits and frees move the tail of the
// table by up to two rows, while a merge can move it further. The block takes one request
// at a time; a finished result waits in the output register while the next request is
// already accepted.
`include "physical_extent_allocator_assert.svh"

module physical_extent_allocator #(
    parameter int TABLE_DEPTH = pea_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // func, address, size_bytes, region_type, page_count (low bit up), zero fill
    input  logic [pea_pkg::IN_W-1:0]     i_s_tdata,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // status, result_address, region_start, region_pages, region_type_out,
    // entries_used (low bit up), zero fill
    output logic [pea_pkg::OUT_W-1:0]    o_m_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    input  logic                         i_cfg_wr_en,
    input  logic [pea_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pea_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import pea_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // control state
    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_svc;
    logic [TYPE_W-1:0] r_free_ty;
    logic              r_ovalid, n_ovalid;

    // request
    logic [FUNC_W-1:0] r_func, n_func;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [REQ_W-1:0]  r_req, n_req;
    logic [TYPE_W-1:0] r_rtype, n_rtype;
    logic [PG_W-1:0]   r_pc, n_pc;

    // scan and walk
    logic              r_fit, n_fit;
    logic [SP_W-1:0]   r_tgt, n_tgt;
    logic [CW-1:0]     r_i, n_i;
    t_row              r_row, n_row;
    logic [SP_W-1:0]   r_acc_sp, n_acc_sp;
    logic [PG_W-1:0]   r_acc_pg, n_acc_pg;
    logic [END_W-1:0]  r_edge, n_edge;
    logic [CW-1:0]     r_lo, n_lo, r_hi, n_hi;
    logic              r_down, n_down;

    // row mover
    logic [CW-1:0]     r_src, n_src, r_dst, n_dst, r_left, n_left;
    logic              r_up, n_up;

    // pending row writes
    logic [1:0]        r_wn, n_wn, r_wk, n_wk;
    logic [CW-1:0]     r_wa [3];
    logic [CW-1:0]     n_wa [3];
    t_row              r_wd [3];
    t_row              n_wd [3];

    // result
    logic [STAT_W-1:0] r_st, n_st;
    logic [ADDR_W-1:0] r_raddr, n_raddr;
    t_row              r_res, n_res;

    // output register
    logic [STAT_W-1:0] r_o_st, n_o_st;
    logic [ADDR_W-1:0] r_o_raddr, n_o_raddr;
    t_row              r_o_res, n_o_res;
    logic [USED_W-1:0] r_o_used, n_o_used;

    // table RAM
    logic          ram_we;
    logic [CW-1:0] ram_waddr, ram_raddr;
    t_row          ram_wdata, rd;
    logic [ROW_W-1:0] ram_rdata;

    pea_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[IW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[IW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd = t_row'(ram_rdata);

    // input fields
    logic [FUNC_W-1:0] in_func;
    logic [ADDR_W-1:0] in_addr, in_size;
    logic [TYPE_W-1:0] in_rtype;
    logic [PG_W-1:0]   in_pc;
    logic [ADDR_W:0]   in_size_up;

    assign in_func    = i_s_tdata[2:0];
    assign in_addr    = i_s_tdata[50:3];
    assign in_size    = i_s_tdata[98:51];
    assign in_rtype   = i_s_tdata[103:99];
    assign in_pc      = i_s_tdata[139:104];
    assign in_size_up = {1'b0, in_size} + (ADDR_W+1)'(4095);

    // shared compare and add terms
    logic [END_W-1:0]  rd_end, a_ep, a_ae, a_after;
    logic [SP_W-1:0]   a_before;
    logic              hit_find, hit_fit, a_fits, has_b, has_a;
    logic [1:0]        need;
    logic              room;
    logic [TYPE_W-1:0] w_ty;
    logic              down_match, up_match, is_merge;
    logic [PG_W-1:0]   acc_sum;
    logic [CW-1:0]     hi_nx;
    logic [SP_W-1:0]   addr_page;

    assign addr_page  = {1'b0, r_addr[ADDR_W-1:PAGE_SHIFT]};
    assign rd_end     = END_W'(rd.sp) + END_W'(rd.pg);
    assign hit_find   = (rd.sp <= r_tgt) && (END_W'(r_tgt) < rd_end);
    assign hit_fit    = (rd.ty == r_free_ty) && (REQ_W'(rd.pg) >= r_req);
    assign a_ep       = END_W'(r_row.sp) + END_W'(r_row.pg);
    assign a_ae       = END_W'(r_tgt) + END_W'(r_req);
    assign a_fits     = a_ae <= a_ep;
    assign a_before   = r_tgt - r_row.sp;
    assign a_after    = a_ep - a_ae;
    assign has_b      = a_before != '0;
    assign has_a      = a_after != '0;
    assign need       = {1'b0, has_b} + {1'b0, has_a};
    assign room       = ({1'b0, r_count} + (CW+1)'(need)) <= (CW+1)'(TABLE_DEPTH);
    assign is_merge   = r_func == FN_MERGE;
    assign w_ty       = is_merge ? r_row.ty : r_free_ty;
    assign down_match = (rd.ty == w_ty) && (rd_end == END_W'(r_acc_sp));
    assign up_match   = (rd.ty == w_ty) && (r_edge == END_W'(rd.sp));
    assign acc_sum    = sat_add(r_acc_pg, rd.pg);
    assign hi_nx      = r_hi + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovalid = r_ovalid;
        n_func   = r_func;
        n_addr   = r_addr;
        n_req    = r_req;
        n_rtype  = r_rtype;
        n_pc     = r_pc;
        n_fit    = r_fit;
        n_tgt    = r_tgt;
        n_i      = r_i;
        n_row    = r_row;
        n_acc_sp = r_acc_sp;
        n_acc_pg = r_acc_pg;
        n_edge   = r_edge;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_down   = r_down;
        n_src    = r_src;
        n_dst    = r_dst;
        n_left   = r_left;
        n_up     = r_up;
        n_wn     = r_wn;
        n_wk     = r_wk;
        n_wa     = r_wa;
        n_wd     = r_wd;
        n_st     = r_st;
        n_raddr  = r_raddr;
        n_res    = r_res;
        n_o_st    = r_o_st;
        n_o_raddr = r_o_raddr;
        n_o_res   = r_o_res;
        n_o_used  = r_o_used;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;
        o_s_tready = r_state == S_IDLE;

        if (r_ovalid && i_m_tready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_func  = in_func;
                    n_addr  = in_addr;
                    n_req   = in_size_up[ADDR_W:PAGE_SHIFT];
                    n_rtype = in_rtype;
                    n_pc    = in_pc;
                    n_raddr = in_addr;
                    n_st    = ST_INVALID;
                    n_res   = '0;
                    n_wn    = '0;
                    n_wk    = '0;
                    n_fit   = 1'b0;
                    n_i     = '0;
                    n_left  = '0;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_tgt   = addr_page;
                n_state = S_DONE;
                if (!r_svc && (r_func == FN_FIXED || r_func == FN_FIRST_FIT ||
                               r_func == FN_FREE || r_func == FN_MERGE)) begin
                    n_st = ST_INVALID;
                end else begin
                    unique case (r_func)
                        FN_LOAD: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_st = ST_FULL;
                            end else begin
                                n_wa[0] = r_count;
                                n_wd[0] = mk_row(addr_page, r_pc, r_rtype);
                                n_res   = mk_row(addr_page, r_pc, r_rtype);
                                n_wn    = 2'd1;
                                n_count = r_count + 1'b1;
                                n_st    = ST_OK;
                                n_state = S_WRITE;
                            end
                        end
                        FN_FIXED: begin
                            if (r_req == '0 || r_addr[PAGE_SHIFT-1:0] != '0) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_state = S_SCAN_RD;
                            end
                        end
                        FN_FIRST_FIT: begin
                            if (r_req == '0) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_fit   = 1'b1;
                                n_state = S_SCAN_RD;
                            end
                        end
                        FN_FREE, FN_QUERY, FN_MERGE: begin
                            n_state = S_SCAN_RD;
                        end
                        default: begin
                            n_st = ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN_RD: begin
                if (r_i >= r_count) begin
                    n_st    = (r_fit || r_func == FN_FIXED) ? ST_NOMEM : ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    ram_raddr = r_i;
                    n_state   = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                n_state = S_DONE;
                if (r_fit) begin
                    if (hit_fit) begin
                        // look the chosen start up again as a fixed allocation
                        n_fit   = 1'b0;
                        n_tgt   = rd.sp;
                        n_raddr = {rd.sp[PG_W-1:0], {PAGE_SHIFT{1'b0}}};
                        n_func  = FN_FIXED;
                        n_i     = '0;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                    n_state = S_SCAN_RD;
                end else if (!hit_find) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_row    = rd;
                    n_acc_sp = rd.sp;
                    n_acc_pg = rd.pg;
                    n_edge   = rd_end;
                    n_lo     = r_i;
                    n_hi     = r_i;
                    n_down   = 1'b1;
                    unique case (r_func)
                        FN_QUERY: begin
                            n_st  = ST_OK;
                            n_res = rd;
                        end
                        FN_FIXED: begin
                            n_state = S_ALLOC;
                        end
                        FN_FREE: begin
                            if (rd.sp != r_tgt || r_addr[PAGE_SHIFT-1:0] != '0) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_state = S_WALK_RD;
                            end
                        end
                        default: begin
                            if (rd.ty == r_free_ty) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_state = S_WALK_RD;
                            end
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                n_state = S_DONE;
                if (r_row.ty != r_free_ty || !a_fits) begin
                    n_st = ST_NOMEM;
                end else if (!room) begin
                    n_st = ST_FULL;
                end else begin
                    n_st    = ST_OK;
                    n_up    = 1'b0;
                    n_src   = r_count - 1'b1;
                    n_dst   = r_count - 1'b1 + CW'(need);
                    n_count = r_count + CW'(need);
                    n_state = S_SHIFT_RD;
                    priority if (has_b && has_a) begin
                        n_left  = r_count - r_i - 1'b1;
                        n_wa[0] = r_i;
                        n_wd[0] = mk_row(r_row.sp, a_before[PG_W-1:0], r_row.ty);
                        n_wa[1] = r_i + 1'b1;
                        n_wd[1] = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_wa[2] = r_i + 2'd2;
                        n_wd[2] = mk_row(a_ae[SP_W-1:0], a_after[PG_W-1:0], r_free_ty);
                        n_res   = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_wn    = 2'd3;
                    end else if (has_b) begin
                        n_left  = r_count - r_i - 1'b1;
                        n_wa[0] = r_i;
                        n_wd[0] = mk_row(r_row.sp, a_before[PG_W-1:0], r_row.ty);
                        n_wa[1] = r_i + 1'b1;
                        n_wd[1] = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_res   = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_wn    = 2'd2;
                    end else if (has_a) begin
                        n_left  = r_count - r_i;
                        n_wa[0] = r_i;
                        n_wd[0] = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_wa[1] = r_i + 1'b1;
                        n_wd[1] = mk_row(a_ae[SP_W-1:0], a_after[PG_W-1:0], r_free_ty);
                        n_res   = mk_row(r_tgt, r_req[PG_W-1:0], r_rtype);
                        n_wn    = 2'd2;
                    end else begin
                        n_left  = '0;
                        n_wa[0] = r_i;
                        n_wd[0] = mk_row(r_row.sp, r_row.pg, r_rtype);
                        n_res   = mk_row(r_row.sp, r_row.pg, r_rtype);
                        n_wn    = 2'd1;
                    end
                end
            end
            S_WALK_RD: begin
                if (r_down) begin
                    if (r_lo == '0) begin
                        n_down = 1'b0;
                    end else begin
                        ram_raddr = r_lo - 1'b1;
                        n_state   = S_WALK_EV;
                    end
                end else if (hi_nx >= r_count) begin
                    n_state = S_WALK_END;
                end else begin
                    ram_raddr = hi_nx;
                    n_state   = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                n_state = S_WALK_RD;
                if (r_down) begin
                    if (down_match) begin
                        n_lo     = r_lo - 1'b1;
                        n_acc_sp = rd.sp;
                        n_acc_pg = acc_sum;
                    end
                    // a free looks at one neighbor each way; a merge runs on
                    if (!is_merge || !down_match) begin
                        n_down = 1'b0;
                    end
                end else begin
                    if (up_match) begin
                        n_hi     = hi_nx;
                        n_acc_pg = acc_sum;
                        n_edge   = rd_end;
                    end
                    if (!is_merge || !up_match) begin
                        n_state = S_WALK_END;
                    end
                end
            end
            S_WALK_END: begin
                n_wa[0] = r_lo;
                n_wd[0] = mk_row(r_acc_sp, r_acc_pg, w_ty);
                n_res   = mk_row(r_acc_sp, r_acc_pg, w_ty);
                n_wn    = 2'd1;
                n_st    = ST_OK;
                // close the gap left by the joined rows
                n_up    = 1'b1;
                n_src   = hi_nx;
                n_dst   = r_lo + 1'b1;
                n_left  = r_count - hi_nx;
                n_count = r_count - (r_hi - r_lo);
                n_state = S_SHIFT_RD;
            end
            S_SHIFT_RD: begin
                if (r_left == '0) begin
                    n_state = S_WRITE;
                end else begin
                    ram_raddr = r_src;
                    n_state   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_dst;
                ram_wdata = rd;
                n_src     = r_up ? r_src + 1'b1 : r_src - 1'b1;
                n_dst     = r_up ? r_dst + 1'b1 : r_dst - 1'b1;
                n_left    = r_left - 1'b1;
                n_state   = S_SHIFT_RD;
            end
            S_WRITE: begin
                if (r_wk == r_wn) begin
                    n_state = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_wa[r_wk];
                    ram_wdata = r_wd[r_wk];
                    n_wk      = r_wk + 1'b1;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid  = 1'b1;
                    n_o_st    = r_st;
                    n_o_raddr = r_raddr;
                    n_o_res   = (r_st == ST_OK) ? r_res : '0;
                    n_o_used  = USED_W'(r_count);
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_svc     <= 1'b0;
            r_free_ty <= FREE_TYPE_RST;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_SERVICE:   r_svc     <= i_cfg_data[0];
                    CFG_FREE_TYPE: r_free_ty <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_addr    <= n_addr;
        r_req     <= n_req;
        r_rtype   <= n_rtype;
        r_pc      <= n_pc;
        r_fit     <= n_fit;
        r_tgt     <= n_tgt;
        r_i       <= n_i;
        r_row     <= n_row;
        r_acc_sp  <= n_acc_sp;
        r_acc_pg  <= n_acc_pg;
        r_edge    <= n_edge;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_down    <= n_down;
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_left    <= n_left;
        r_up      <= n_up;
        r_wn      <= n_wn;
        r_wk      <= n_wk;
        r_wa      <= n_wa;
        r_wd      <= n_wd;
        r_st      <= n_st;
        r_raddr   <= n_raddr;
        r_res     <= n_res;
        r_o_st    <= n_o_st;
        r_o_raddr <= n_o_raddr;
        r_o_res   <= n_o_res;
        r_o_used  <= n_o_used;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {3'b000, r_o_used, r_o_res.ty, r_o_res.pg,
                         r_o_res.sp[PG_W-1:0], {PAGE_SHIFT{1'b0}}, r_o_raddr, r_o_st};

    `PEA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_DEPTH))
    `PEA_ASSERT_NEXT(a_accept_decode, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_state == S_DECODE)
    `PEA_ASSERT_NOW(a_write_in_table, i_clk, i_rst_n, ram_we, ram_waddr < r_count)
    `PEA_ASSERT_NOW(a_fail_no_region, i_clk, i_rst_n, r_ovalid && r_o_st != ST_OK, r_o_res == '0)

endmodule

[rtl/core/pea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
